>>> design/gsfp_pkg.sv
// shared types, status codes and register map for the guarded stack frame pool
package gsfp_pkg;

  // fixed field widths
  localparam int ADDR_W     = 48;
  localparam int SHIFT_W    = 5;
  localparam int PAGES_W    = 16;
  localparam int COUNT_W    = 11;
  localparam int STATUS_W   = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 2;

  typedef logic [STATUS_W-1:0] status_t;

  // result status codes
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_EMPTY      = 3'd1;
  localparam status_t ST_MISALIGNED = 3'd2;
  localparam status_t ST_RANGE      = 3'd3;
  localparam status_t ST_DOUBLE     = 3'd4;

  // register indexes, byte address is 8 times the index
  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAGES = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
  localparam logic [PAGES_W-1:0] PAGES_RST = 16'd3;
  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

  // pool geometry as seen by the datapath
  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [SHIFT_W-1:0] page_shift;
    logic [PAGES_W-1:0] frame_pages;
    logic [COUNT_W-1:0] frame_count;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic    ld_in;
    logic    setup;
    logic    pop;
    logic    take_fresh;
    logic    ld_pop_idx;
    logic    mark;
    logic    calc_addr;
    logic    div_load;
    logic    div_step;
    logic    map_read;
    logic    release_frame;
    logic    st_ld;
    status_t st_code;
    logic    out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_free;
    logic stk_nonempty;
    logic fresh_avail;
    logic misaligned;
    logic below_base;
    logic q_over;
    logic q_unused;
    logic map_bit;
  } dp_sts_t;

endpackage

>>> design/gsfp_cfg_regs.sv
// configuration register bank behind the register access port
module gsfp_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [gsfp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gsfp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gsfp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output gsfp_pkg::cfg_t                     cfg
);
  import gsfp_pkg::*;

  logic [ADDR_W-1:0]    base_address_r;
  logic [SHIFT_W-1:0]   page_shift_r;
  logic [PAGES_W-1:0]   frame_pages_r;
  logic [COUNT_W-1:0]   frame_count_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= BASE_RST;
      page_shift_r   <= SHIFT_RST;
      frame_pages_r  <= PAGES_RST;
      frame_count_r  <= COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE:  base_address_r <= cfg_pwdata[ADDR_W-1:0];
        REG_SHIFT: page_shift_r   <= cfg_pwdata[SHIFT_W-1:0];
        REG_PAGES: frame_pages_r  <= cfg_pwdata[PAGES_W-1:0];
        REG_COUNT: frame_count_r  <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_BASE:  cfg_prdata = CFG_DATA_W'(base_address_r);
      REG_SHIFT: cfg_prdata = CFG_DATA_W'(page_shift_r);
      REG_PAGES: cfg_prdata = CFG_DATA_W'(frame_pages_r);
      REG_COUNT: cfg_prdata = CFG_DATA_W'(frame_count_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.base_address = base_address_r;
  assign cfg.page_shift   = page_shift_r;
  assign cfg.frame_pages  = frame_pages_r;
  assign cfg.frame_count  = frame_count_r;

endmodule

>>> design/gsfp_ctrl.sv
// sequencing state machine for allocate and free requests
module gsfp_ctrl #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  gsfp_pkg::dp_sts_t    sts,
  output gsfp_pkg::ctrl_cmd_t  cmd
);
  import gsfp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int STEP_W = $clog2(IDX_W + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_MARK  = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_BOUND = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_RCHK  = 4'd7;
  localparam logic [3:0] S_RMAP  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.is_free) begin
          state_nxt = S_BOUND;
        end else if (sts.stk_nonempty) begin
          cmd.pop   = 1'b1;
          state_nxt = S_POP;
        end else if (sts.fresh_avail) begin
          cmd.take_fresh = 1'b1;
          state_nxt      = S_MARK;
        end else begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_EMPTY;
          state_nxt   = S_DONE;
        end
      end
      S_POP: begin
        cmd.ld_pop_idx = 1'b1;
        state_nxt      = S_MARK;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        cmd.st_ld     = 1'b1;
        cmd.st_code   = ST_OK;
        state_nxt     = S_DONE;
      end
      S_BOUND: begin
        if (sts.misaligned) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_MISALIGNED;
          state_nxt   = S_DONE;
        end else if (sts.below_base) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_RANGE;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = STEP_W'(IDX_W);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_RCHK;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      S_RCHK: begin
        if (sts.q_over) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_RANGE;
          state_nxt   = S_DONE;
        end else if (sts.q_unused) begin
          // frames at or past the fresh pointer were never handed out
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_DOUBLE;
          state_nxt   = S_DONE;
        end else begin
          cmd.map_read = 1'b1;
          state_nxt    = S_RMAP;
        end
      end
      S_RMAP: begin
        cmd.st_ld = 1'b1;
        if (!sts.map_bit) begin
          cmd.st_code = ST_DOUBLE;
        end else begin
          cmd.release_frame = 1'b1;
          cmd.st_code       = ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted word always starts the setup step
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SETUP))
    else $error("accepted word did not enter setup");

  // divider loop leaves after the last step
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_RCHK))
    else $error("divider loop did not finish");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

endmodule

>>> design/gsfp_dpath.sv
// datapath: free stack, in-use map, frame divider and address math
module gsfp_dpath #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gsfp_pkg::cfg_t                cfg,
  input  gsfp_pkg::ctrl_cmd_t           cmd,
  output gsfp_pkg::dp_sts_t             sts,
  input  logic [gsfp_pkg::ADDR_W-1:0]   in_tdata,
  input  logic [0:0]                    in_tuser,
  output logic [gsfp_pkg::ADDR_W-1:0]   out_tdata,
  output logic [gsfp_pkg::STATUS_W-1:0] out_tuser
);
  import gsfp_pkg::*;

  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int PROD_W = IDX_W + PAGES_W;
  localparam int DIV_W  = ADDR_W + IDX_W;

  // request and working registers
  logic [ADDR_W-1:0] addr_in_r;
  logic              is_free_r;
  logic [ADDR_W:0]   bp_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PROD_W-1:0] prod_r;
  logic [ADDR_W-1:0] addr_r;
  status_t           status_r;
  logic [ADDR_W-1:0] rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [IDX_W:0]    q_r;
  logic [CNT_W-1:0]  freed_count_r, freed_count_nxt;
  logic [CNT_W-1:0]  fresh_next_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;

  // memories
  logic [IDX_W-1:0]  stk_mem [MAX_FRAMES];
  logic              map_mem [MAX_FRAMES];
  logic [IDX_W-1:0]  stk_rd_r;
  logic              map_rd_r;

  logic [PAGES_W-1:0] pages_eff;
  logic [ADDR_W-1:0]  page;
  logic [ADDR_W-1:0]  fsize;
  logic [CNT_W-1:0]   cnt_dec;
  logic [IDX_W-1:0]   q_low;
  logic [DIV_W:0]     trial;
  logic               div_ge;
  logic               push_ok;
  logic               map_we;
  logic [IDX_W-1:0]   map_waddr;

  // geometry from the registers
  assign pages_eff = (cfg.frame_pages == '0) ? PAGES_W'(1) : cfg.frame_pages;
  assign page      = ADDR_W'(1) << cfg.page_shift;
  assign fsize     = ADDR_W'(pages_eff) << cfg.page_shift;
  assign cnt_dec   = freed_count_r - CNT_W'(1);
  assign q_low     = q_r[IDX_W-1:0];
  assign push_ok   = (32'(freed_count_r) < MAX_FRAMES);

  // one restoring divide step
  assign trial  = {1'b0, DIV_W'(rem_r)} - {1'b0, dvs_r};
  assign div_ge = ~trial[DIV_W];

  // status toward the controller
  assign sts.is_free      = is_free_r;
  assign sts.stk_nonempty = (freed_count_r != '0);
  assign sts.fresh_avail  = (32'(fresh_next_r) < 32'(cfg.frame_count)) &&
                            (32'(fresh_next_r) < MAX_FRAMES);
  assign sts.misaligned   = |(addr_in_r & (page - ADDR_W'(1)));
  assign sts.below_base   = ({1'b0, addr_in_r} < bp_r);
  assign sts.q_over       = q_r[IDX_W] ||
                            (32'(q_low) >= 32'(cfg.frame_count)) ||
                            (32'(q_low) >= MAX_FRAMES);
  assign sts.q_unused     = (CNT_W'(q_low) >= fresh_next_r);
  assign sts.map_bit      = map_rd_r;

  // request capture, address math and divider
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      addr_in_r <= in_tdata;
      is_free_r <= in_tuser[0];
    end
    if (cmd.setup) begin
      bp_r <= {1'b0, cfg.base_address} + {1'b0, page};
    end
    if (cmd.take_fresh) begin
      idx_r <= fresh_next_r[IDX_W-1:0];
    end else if (cmd.ld_pop_idx) begin
      idx_r <= stk_rd_r;
    end
    if (cmd.mark) begin
      prod_r <= PROD_W'(idx_r) * PROD_W'(pages_eff);
    end
    if (cmd.calc_addr) begin
      addr_r <= bp_r[ADDR_W-1:0] + (ADDR_W'(prod_r) << cfg.page_shift);
    end
    if (cmd.div_load) begin
      rem_r <= addr_in_r - bp_r[ADDR_W-1:0];
      dvs_r <= DIV_W'(fsize) << IDX_W;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= trial[ADDR_W-1:0];
      end
      dvs_r <= dvs_r >> 1;
      q_r   <= {q_r[IDX_W-1:0], div_ge};
    end
    if (cmd.st_ld) begin
      status_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_addr_r   <= (status_r == ST_OK && !is_free_r) ? addr_r : '0;
    end
  end

  // freed stack count
  always_comb begin
    freed_count_nxt = freed_count_r;
    if (cmd.pop) begin
      freed_count_nxt = cnt_dec;
    end else if (cmd.release_frame && push_ok) begin
      freed_count_nxt = freed_count_r + CNT_W'(1);
    end
  end

  // pool counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freed_count_r <= '0;
      fresh_next_r  <= '0;
    end else begin
      freed_count_r <= freed_count_nxt;
      if (cmd.take_fresh) begin
        fresh_next_r <= fresh_next_r + CNT_W'(1);
      end
    end
  end

  // freed index stack
  always_ff @(posedge clk) begin
    if (cmd.release_frame && push_ok) begin
      stk_mem[freed_count_r[IDX_W-1:0]] <= q_low;
    end
    if (cmd.pop) begin
      stk_rd_r <= stk_mem[cnt_dec[IDX_W-1:0]];
    end
  end

  // in-use map, entries at or past the fresh pointer read as clear
  assign map_we    = cmd.mark | cmd.release_frame;
  assign map_waddr = cmd.mark ? idx_r : q_low;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= cmd.mark;
    end
    if (cmd.map_read) begin
      map_rd_r <= map_mem[q_low];
    end
  end

  assign out_tdata = out_addr_r;
  assign out_tuser = out_status_r;

  // each stacked index was handed out fresh once
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    freed_count_r <= fresh_next_r)
    else $error("freed stack deeper than frames handed out");

  // pop only from a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (freed_count_r != '0))
    else $error("pop from empty freed stack");

endmodule

>>> design/guarded_stack_frame_pool.sv
// top level of the guarded stack frame pool allocator
//
//  port group | dir    | words
//  in_*       | slave  | tuser: cmd, tdata: free_address
//  out_*      | master | tuser: status, tdata: payload_address
//  cfg_*      | slave  | register access, 64-bit data, registers at 8*index
//
// allocate: setup, pop of a freed frame if any, mark, address; refused at
// setup on an empty pool. free: setup, bound check, bit-serial divider, range
// check, map read; refused at the bound check when misaligned or below frame 0
// one request is worked at a time; a new one is taken while a result waits
// synchronous active-low reset, no clearing pass: the in-use map is
// qualified by the fresh-frame pointer
module guarded_stack_frame_pool #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gsfp_pkg::ADDR_W-1:0]        in_tdata,    // [47:0] free_address
  input  logic [0:0]                         in_tuser,    // [0] cmd
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gsfp_pkg::ADDR_W-1:0]        out_tdata,   // [47:0] payload_address
  output logic [gsfp_pkg::STATUS_W-1:0]      out_tuser,   // [2:0] status
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [gsfp_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gsfp_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gsfp_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import gsfp_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // register bank
  gsfp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // controller
  gsfp_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath
  gsfp_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> dv/guarded_stack_frame_pool_tb.sv
// self-checking testbench for the guarded stack frame pool allocator
module guarded_stack_frame_pool_tb;
  import gsfp_pkg::*;

  localparam int POOL_DEPTH    = 1024;
  localparam bit CMD_ALLOC     = 1'b0;
  localparam bit CMD_FREE      = 1'b1;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_WORDS   = 40;
  localparam int REFILL_FRAMES = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_CAP    = 30;
  localparam int MAX_GAP       = 17;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [ADDR_W-1:0]     out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // one expected result word
  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] payload;
  } answer_t;

  answer_t pending_answers[$];

  // mirrored geometry registers
  logic [ADDR_W-1:0]  geo_base;
  logic [SHIFT_W-1:0] geo_shift;
  logic [PAGES_W-1:0] geo_pages;
  logic [COUNT_W-1:0] geo_count;

  // mirrored pool state
  bit          frame_busy [POOL_DEPTH];
  int unsigned freed_frames [POOL_DEPTH];
  int unsigned freed_depth;
  int unsigned fresh_next;

  int mismatch_count;
  bit tx_steady;
  bit rx_steady;
  int rx_hold_req;

  guarded_stack_frame_pool #(
    .MAX_FRAMES(POOL_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // geometry helpers
  function automatic logic [63:0] page_bytes();
    return 64'd1 << geo_shift;
  endfunction

  function automatic logic [63:0] frame_bytes();
    logic [63:0] pages;
    pages = (geo_pages == '0) ? 64'd1 : 64'(geo_pages);
    return pages << geo_shift;
  endfunction

  function automatic int unsigned usable_frames();
    return (geo_count > POOL_DEPTH) ? POOL_DEPTH : int'(geo_count);
  endfunction

  function automatic logic [ADDR_W-1:0] frame_address(input int unsigned idx,
                                                       input int unsigned page_off);
    logic [63:0] a;
    a = 64'(geo_base) + 64'(idx) * frame_bytes() + page_bytes() * (64'(page_off) + 64'd1);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void reset_pool_mirror();
    geo_base    = BASE_RST;
    geo_shift   = SHIFT_RST;
    geo_pages   = PAGES_RST;
    geo_count   = COUNT_RST;
    freed_depth = 0;
    fresh_next  = 0;
    for (int i = 0; i < POOL_DEPTH; i++) frame_busy[i] = 1'b0;
  endfunction

  // allocator behavior for one accepted request word
  function automatic answer_t predict_pool_answer(input bit cmd,
                                                  input logic [ADDR_W-1:0] addr);
    answer_t     ans;
    logic [63:0] page;
    logic [63:0] fsize;
    logic [63:0] p;
    logic [63:0] idx;
    int unsigned slot;
    bit          got;
    page        = page_bytes();
    fsize       = frame_bytes();
    ans.status  = ST_OK;
    ans.payload = '0;
    got         = 1'b0;
    slot        = 0;
    if (cmd == CMD_ALLOC) begin
      // freed frames first, newest on top, then never-used ones
      if (freed_depth > 0) begin
        freed_depth--;
        slot = freed_frames[freed_depth];
        got  = 1'b1;
      end else if (fresh_next < usable_frames()) begin
        slot = fresh_next;
        fresh_next++;
        got  = 1'b1;
      end
      if (got) begin
        frame_busy[slot] = 1'b1;
        p = 64'(geo_base) + 64'(slot) * fsize + page;
        ans.payload = p[ADDR_W-1:0];
      end else begin
        ans.status = ST_EMPTY;
      end
    end else begin
      p = 64'(addr);
      if ((p & (page - 64'd1)) != 0) begin
        ans.status = ST_MISALIGNED;
      end else if (p < 64'(geo_base) + page) begin
        ans.status = ST_RANGE;
      end else begin
        idx = (p - 64'(geo_base) - page) / fsize;
        if (idx >= 64'(usable_frames())) begin
          ans.status = ST_RANGE;
        end else if (!frame_busy[int'(idx)]) begin
          ans.status = ST_DOUBLE;
        end else begin
          slot = int'(idx);
          frame_busy[slot] = 1'b0;
          if (freed_depth < POOL_DEPTH) begin
            freed_frames[freed_depth] = slot;
            freed_depth++;
          end
        end
      end
    end
    return ans;
  endfunction

  // payload address of a random frame in use, maybe a page further inside
  function automatic logic [ADDR_W-1:0] live_frame_address(output bit found);
    int unsigned cands[$];
    int unsigned pick;
    int unsigned span;
    found = 1'b0;
    for (int i = 0; i < usable_frames(); i++) begin
      if (frame_busy[i]) cands.push_back(i);
    end
    if (cands.size() == 0) return '0;
    found = 1'b1;
    pick  = cands[$urandom_range(0, cands.size() - 1)];
    span  = (geo_pages > 2) ? int'(geo_pages) - 2 : 0;
    return frame_address(pick, $urandom_range(0, 1) ? 0 : $urandom_range(0, span));
  endfunction

  // addresses likely to be refused, plus the start of an arbitrary frame
  function automatic logic [ADDR_W-1:0] stray_address();
    logic [63:0] a;
    logic [63:0] lim;
    logic [63:0] page;
    page = page_bytes();
    case ($urandom_range(0, 4))
      0: begin
        a = 64'(random_address());
        if (geo_shift != 0 && (a & (page - 64'd1)) == 0)
          a = a | (64'd1 << $urandom_range(0, geo_shift - 1));
      end
      1: begin
        lim = 64'(geo_base) + page;
        a   = ({$urandom, $urandom} % lim) & ~(page - 64'd1);
      end
      2: a = 64'(frame_address(usable_frames() + $urandom_range(0, 3), 0));
      3: a = 64'(frame_address($urandom_range(0, POOL_DEPTH - 1), 0));
      default: a = 64'(random_address());
    endcase
    return a[ADDR_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  // offer one request word and record what it must produce
  task automatic push_request(input bit cmd, input logic [ADDR_W-1:0] addr,
                              output answer_t want);
    int gap;
    gap = draw_gap(tx_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    want = predict_pool_answer(cmd, addr);
    pending_answers.push_back(want);
  endtask

  // drain every outstanding result, then let the block go quiet
  task automatic settle_pool();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_reg(input logic [REG_IDX_W-1:0] which,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({which, 3'b000});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (which)
      REG_BASE:  geo_base  = value[ADDR_W-1:0];
      REG_SHIFT: geo_shift = value[SHIFT_W-1:0];
      REG_PAGES: geo_pages = value[PAGES_W-1:0];
      REG_COUNT: geo_count = value[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random geometry, a random subset of registers rewritten
  task automatic pick_geometry();
    logic [SHIFT_W-1:0] shift;
    logic [PAGES_W-1:0] pages;
    logic [COUNT_W-1:0] count;
    logic [63:0]        base;
    logic [63:0]        page_mask;
    int unsigned        sel;
    shift     = SHIFT_W'($urandom_range(12, 16));
    page_mask = ~((64'd1 << shift) - 64'd1);
    case ($urandom_range(0, 9))
      0:       pages = '1;
      1:       pages = '0;
      2:       pages = PAGES_W'($urandom);
      default: pages = PAGES_W'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 9))
      0:       count = '0;
      1:       count = COUNT_W'(POOL_DEPTH);
      2:       count = COUNT_W'($urandom_range(POOL_DEPTH + 1, 2047));
      3:       count = COUNT_W'($urandom_range(0, 2047));
      default: count = COUNT_W'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    base = '0;
      2:       base = 64'({ADDR_W{1'b1}}) & page_mask;
      3:       base = 64'(random_address());
      default: base = {$urandom, $urandom} & 64'hFF_FFFF_FFFF & page_mask;
    endcase
    sel = $urandom_range(1, 15);
    if (sel[1]) write_pool_reg(REG_SHIFT, 64'(shift));
    if (sel[0]) write_pool_reg(REG_BASE, base & 64'hFFFF_FFFF_FFFF);
    if (sel[2]) write_pool_reg(REG_PAGES, 64'(pages));
    if (sel[3]) write_pool_reg(REG_COUNT, 64'(count));
  endtask

  // reset geometry: lifo reuse, misaligned, range and double-free refusals, free inside a frame
  task automatic test_reset_geometry();
    answer_t got;
    push_request(CMD_ALLOC, '0, got);
    push_request(CMD_ALLOC, '1, got);
    push_request(CMD_FREE, frame_address(1, 0), got);
    push_request(CMD_ALLOC, random_address(), got);
    push_request(CMD_FREE, frame_address(1, 0) | 48'h1, got);
    push_request(CMD_FREE, '0, got);
    push_request(CMD_FREE, frame_address(5, 0), got);
    push_request(CMD_FREE, frame_address(POOL_DEPTH, 0), got);
    push_request(CMD_FREE, '1, got);
    push_request(CMD_FREE, {{(ADDR_W - 12){1'b1}}, 12'h000}, got);
    push_request(CMD_FREE, frame_address(0, 1), got);
    push_request(CMD_FREE, frame_address(0, 0), got);
    push_request(CMD_FREE, frame_address(1, 1), got);
    push_request(CMD_ALLOC, random_address(), got);
    push_request(CMD_ALLOC, random_address(), got);
  endtask

  // zero pages, zero count, oversized count and a wrapping top base
  task automatic test_odd_geometry();
    answer_t got;
    settle_pool();
    write_pool_reg(REG_PAGES, 64'd0);
    write_pool_reg(REG_SHIFT, 64'd16);
    write_pool_reg(REG_BASE, 64'h1_0000);
    write_pool_reg(REG_COUNT, 64'd4);
    push_request(CMD_FREE, frame_address(1, 0), got);
    push_request(CMD_FREE, frame_address(0, 0), got);
    settle_pool();
    // only stacked frames can come back with an empty fresh range
    write_pool_reg(REG_COUNT, 64'd0);
    push_request(CMD_ALLOC, random_address(), got);
    push_request(CMD_ALLOC, random_address(), got);
    push_request(CMD_ALLOC, random_address(), got);
    push_request(CMD_FREE, frame_address(0, 0), got);
    settle_pool();
    write_pool_reg(REG_BASE, 64'hFFFF_FFFF_0000);
    write_pool_reg(REG_PAGES, 64'hFFFF);
    write_pool_reg(REG_COUNT, 64'h7FF);
    push_request(CMD_ALLOC, random_address(), got);
    push_request(CMD_FREE, frame_address(2, 0), got);
    push_request(CMD_FREE, frame_address(2, 3), got);
  endtask

  // mostly well-formed alloc/free traffic over many geometries
  task automatic test_random_traffic();
    answer_t           got;
    logic [ADDR_W-1:0] addr;
    bit                found;
    int                roll;
    int                alloc_pct;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_pool();
      pick_geometry();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      alloc_pct = $urandom_range(30, 65);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          push_request(CMD_ALLOC, random_address(), got);
        end else if (roll < 88) begin
          addr = live_frame_address(found);
          if (found) push_request(CMD_FREE, addr, got);
          else push_request(CMD_ALLOC, random_address(), got);
        end else begin
          push_request(CMD_FREE, stray_address(), got);
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // run the full pool dry, then free a shuffled batch and reuse it
  task automatic test_pool_exhaustion();
    answer_t     got;
    int unsigned order[$];
    int unsigned tmp;
    int          j;
    int          guard;
    settle_pool();
    write_pool_reg(REG_BASE, 64'd0);
    write_pool_reg(REG_SHIFT, 64'd12);
    write_pool_reg(REG_PAGES, 64'd2);
    write_pool_reg(REG_COUNT, 64'(POOL_DEPTH));
    tx_steady  = 1'b1;
    rx_steady  = 1'b1;
    got.status = ST_OK;
    guard      = 0;
    while (got.status != ST_EMPTY && guard < 2 * POOL_DEPTH + 8) begin
      push_request(CMD_ALLOC, random_address(), got);
      guard++;
    end
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (frame_busy[i]) order.push_back(i);
    end
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    rx_steady = 1'b0;
    for (int i = 0; i < order.size() && i < REFILL_FRAMES; i++) begin
      push_request(CMD_FREE, frame_address(order[i], 0), got);
    end
    for (int n = 0; n < 8; n++) push_request(CMD_ALLOC, random_address(), got);
    tx_steady = 1'b0;
  endtask

  // long output stall while requests keep coming
  task automatic test_output_backpressure();
    answer_t           got;
    logic [ADDR_W-1:0] addr;
    bit                found;
    settle_pool();
    tx_steady   = 1'b1;
    rx_hold_req = HOLD_CYCLES;
    for (int n = 0; n < 24; n++) begin
      addr = live_frame_address(found);
      if (n % 2 == 0 || !found) push_request(CMD_ALLOC, random_address(), got);
      else push_request(CMD_FREE, addr, got);
    end
    tx_steady = 1'b0;
  endtask

  // result receiver with random stalls and the odd long hold
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = draw_gap(rx_steady);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word: status %0d payload %0h",
                                out_tuser, out_tdata));
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_tuser, want.status));
        if (out_tdata !== want.payload)
          flag_mismatch($sformatf("payload %0h, expected %0h", out_tdata, want.payload));
      end
    end
  end

  // run limit
  initial begin
    #8000000;
    $display("** guarded_stack_frame_pool: FAILED **");
    $finish;
  end

  // test sequence
  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    mismatch_count = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    rx_hold_req    = 0;
    reset_pool_mirror();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_odd_geometry();
    test_random_traffic();
    test_pool_exhaustion();
    test_output_backpressure();
    settle_pool();
    if (mismatch_count == 0) begin
      $display("** guarded_stack_frame_pool: PASSED **");
    end else begin
      $display("** guarded_stack_frame_pool: FAILED **");
    end
    $finish;
  end

endmodule
